FILE: rtl/core/tesw_pkg.sv
// shared types and constants for the triangle edge scan walker
package tesw_pkg;

    localparam int DEF_FRAC_BITS  = 8;
    localparam int DEF_COORD_BITS = 12;

    localparam int EDGE_W    = 32;
    localparam int SLOPE_W   = 24;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT    = 1'd1;

    localparam logic [CFG_W-1:0] COLUMN_LIMIT_RESET = 12'd512;
    localparam logic [CFG_W-1:0] ROW_LIMIT_RESET    = 12'd256;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        SEL_LEFT,
        SEL_RIGHT,
        SEL_RESTART
    } slope_sel_t;

    typedef struct packed {
        logic       capture;
        logic       sort_load;
        logic       div_start;
        slope_sel_t div_sel;
        logic       slope_write;
        logic       setup_emit;
        logic       step_emit;
    } tesw_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } tesw_status_t;

endpackage

FILE: rtl/core/tesw_div.sv
// iterative signed by unsigned divider, one quotient bit per cycle, truncating
module tesw_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 13
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 neg_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;

    logic [DEN_W:0]       shifted;
    logic [DEN_W+1:0]     diff;
    logic                 fits;
    logic [DEN_W-1:0]     rem_next;
    logic [NUM_W-1:0]     quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        fits     = !diff[DEN_W+1];
        rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            quo_reg <= num[NUM_W-1] ? unsigned'(-num) : unsigned'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

endmodule

FILE: rtl/core/tesw_dp.sv
// datapath: vertex sort, slope set-up, edge stepping, config and result registers
module tesw_dp #(
    parameter int FRAC_BITS  = tesw_pkg::DEF_FRAC_BITS,
    parameter int COORD_BITS = tesw_pkg::DEF_COORD_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  tesw_pkg::tesw_cmd_t                      cmd,
    output tesw_pkg::tesw_status_t                   status,
    input  logic                                     cfg_write_en,
    input  logic [tesw_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [tesw_pkg::CFG_W-1:0]               cfg_data,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0]   vert_a_x,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0]   vert_a_y,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0]   vert_b_x,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0]   vert_b_y,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0]   vert_c_x,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0]   vert_c_y,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [COORD_BITS-1:0]             scan_row,
    output logic                                     row_valid,
    output logic signed [COORD_BITS-1:0]             span_left,
    output logic signed [COORD_BITS-1:0]             span_right,
    output logic                                     left_in_range,
    output logic                                     right_in_range,
    output logic                                     last_row
);

    import tesw_pkg::*;

    localparam int IN_W  = COORD_BITS + FRAC_BITS;
    localparam int ROW_W = COORD_BITS + 1;
    localparam int DX_W  = IN_W + 1;
    localparam int QW    = (DX_W > SLOPE_W) ? DX_W : SLOPE_W;

    localparam logic signed [IN_W-1:0]   BIAS_IN =
        {{(IN_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [EDGE_W-1:0] BIAS_EDGE =
        {{(EDGE_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [EDGE_W-1:0] SAT_HI =
        {{(EDGE_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [EDGE_W-1:0] SAT_LO = -SAT_HI - 1;

    function automatic logic signed [ROW_W-1:0] to_row(input logic signed [IN_W-1:0] v);
        logic signed [IN_W-1:0] b;
        b = v + (v[IN_W-1] ? BIAS_IN : '0);
        return ROW_W'(signed'(b[IN_W-1:FRAC_BITS]));
    endfunction

    function automatic logic signed [EDGE_W-1:0] to_col(input logic signed [EDGE_W-1:0] e);
        logic signed [EDGE_W-1:0] b;
        b = e + (e[EDGE_W-1] ? BIAS_EDGE : '0);
        return b >>> FRAC_BITS;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [EDGE_W-1:0] v);
        logic signed [EDGE_W-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[COORD_BITS-1:0];
    endfunction

    function automatic logic can_walk(
        input logic signed [ROW_W-1:0]  row,
        input logic signed [ROW_W-1:0]  fin,
        input logic signed [EDGE_W-1:0] lim
    );
        return (row <= fin) && (EDGE_W'(row) < lim);
    endfunction

    // configuration
    logic [CFG_W-1:0] col_lim_reg;
    logic [CFG_W-1:0] row_lim_reg;
    logic signed [EDGE_W-1:0] col_lim_s;
    logic signed [EDGE_W-1:0] row_lim_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_lim_reg <= COLUMN_LIMIT_RESET;
            row_lim_reg <= ROW_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_COLUMN_LIMIT: col_lim_reg <= cfg_data;
                CFG_ROW_LIMIT:    row_lim_reg <= cfg_data;
            endcase
        end
    end

    assign col_lim_s = signed'(EDGE_W'(col_lim_reg));
    assign row_lim_s = signed'(EDGE_W'(row_lim_reg));

    // captured vertices and sort
    logic signed [IN_W-1:0] vx_reg [3];
    logic signed [IN_W-1:0] vy_reg [3];
    logic signed [IN_W-1:0] sx [3];
    logic signed [IN_W-1:0] sy [3];
    logic signed [IN_W-1:0] tx;
    logic signed [IN_W-1:0] ty;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vx_reg[0] <= vert_a_x;
            vy_reg[0] <= vert_a_y;
            vx_reg[1] <= vert_b_x;
            vy_reg[1] <= vert_b_y;
            vx_reg[2] <= vert_c_x;
            vy_reg[2] <= vert_c_y;
        end
    end

    always_comb
    begin
        sx = vx_reg;
        sy = vy_reg;
        tx = '0;
        ty = '0;
        if (sy[0] > sy[1])
        begin
            tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
            ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
        end
        if (sy[1] > sy[2])
        begin
            tx = sx[1]; sx[1] = sx[2]; sx[2] = tx;
            ty = sy[1]; sy[1] = sy[2]; sy[2] = ty;
        end
        if (sy[0] > sy[1])
        begin
            tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
            ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
        end
    end

    // walker state
    logic signed [ROW_W-1:0]   cur_row_reg;
    logic signed [ROW_W-1:0]   mid_row_reg;
    logic signed [ROW_W-1:0]   fin_row_reg;
    logic signed [IN_W-1:0]    top_x_reg;
    logic signed [IN_W-1:0]    mid_x_reg;
    logic signed [IN_W-1:0]    fin_x_reg;
    logic signed [EDGE_W-1:0]  left_edge_reg;
    logic signed [EDGE_W-1:0]  right_edge_reg;
    logic signed [SLOPE_W-1:0] left_slope_reg;
    logic signed [SLOPE_W-1:0] right_slope_reg;
    logic signed [SLOPE_W-1:0] restart_slope_reg;
    logic                      walking_reg;

    // slope divider operands
    logic signed [DX_W-1:0]  div_num;
    logic signed [ROW_W-1:0] div_dr;
    logic        [ROW_W-1:0] div_den;
    logic                    div_done;
    logic signed [DX_W-1:0]  div_q;
    logic signed [QW-1:0]    q_wide;
    logic signed [SLOPE_W-1:0] slope_new;

    always_comb
    begin
        unique case (cmd.div_sel)
            SEL_LEFT:
            begin
                div_num = DX_W'(mid_x_reg) - DX_W'(top_x_reg);
                div_dr  = mid_row_reg - cur_row_reg;
            end
            SEL_RIGHT:
            begin
                div_num = DX_W'(fin_x_reg) - DX_W'(top_x_reg);
                div_dr  = fin_row_reg - cur_row_reg;
            end
            SEL_RESTART:
            begin
                div_num = DX_W'(fin_x_reg) - DX_W'(mid_x_reg);
                div_dr  = fin_row_reg - mid_row_reg;
            end
            default:
            begin
                div_num = '0;
                div_dr  = '0;
            end
        endcase
        div_den = unsigned'(div_dr) + 1'b1;
    end

    tesw_div #(
        .NUM_W (DX_W),
        .DEN_W (ROW_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign q_wide    = QW'(div_q);
    assign slope_new = q_wide[SLOPE_W-1:0];

    // one scanline
    logic                      at_mid;
    logic signed [EDGE_W-1:0]  eff_left;
    logic signed [SLOPE_W-1:0] eff_lslope;
    logic signed [EDGE_W-1:0]  edge_lo;
    logic signed [EDGE_W-1:0]  edge_hi;
    logic signed [EDGE_W-1:0]  col_l;
    logic signed [EDGE_W-1:0]  col_r;
    logic                      row_ok;
    logic signed [ROW_W-1:0]   row_next;
    logic                      setup_walk;

    always_comb
    begin
        at_mid     = (cur_row_reg == mid_row_reg);
        eff_left   = at_mid ? EDGE_W'(mid_x_reg) : left_edge_reg;
        eff_lslope = at_mid ? restart_slope_reg : left_slope_reg;
        edge_lo    = (eff_left < right_edge_reg) ? eff_left : right_edge_reg;
        edge_hi    = (eff_left < right_edge_reg) ? right_edge_reg : eff_left;
        col_l      = to_col(edge_lo);
        col_r      = to_col(edge_hi);
        row_ok     = (cur_row_reg >= 0) && (EDGE_W'(cur_row_reg) < row_lim_s);
        row_next   = cur_row_reg + ROW_W'(1);
        setup_walk = can_walk(cur_row_reg, fin_row_reg, row_lim_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            walking_reg <= 1'b0;
        end
        else if (cmd.sort_load)
        begin
            cur_row_reg <= to_row(sy[0]);
        end
        else if (cmd.setup_emit)
        begin
            walking_reg <= setup_walk;
        end
        else if (cmd.step_emit && walking_reg)
        begin
            cur_row_reg <= row_next;
            walking_reg <= can_walk(row_next, fin_row_reg, row_lim_s);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_load)
        begin
            mid_row_reg    <= to_row(sy[1]);
            fin_row_reg    <= to_row(sy[2]);
            top_x_reg      <= sx[0];
            mid_x_reg      <= sx[1];
            fin_x_reg      <= sx[2];
            left_edge_reg  <= EDGE_W'(sx[0]);
            right_edge_reg <= EDGE_W'(sx[0]);
        end
        else if (cmd.step_emit && walking_reg)
        begin
            left_edge_reg  <= eff_left + EDGE_W'(eff_lslope);
            left_slope_reg <= eff_lslope;
            right_edge_reg <= right_edge_reg + EDGE_W'(right_slope_reg);
        end
        if (cmd.slope_write)
        begin
            unique case (cmd.div_sel)
                SEL_LEFT:    left_slope_reg    <= slope_new;
                SEL_RIGHT:   right_slope_reg   <= slope_new;
                SEL_RESTART: restart_slope_reg <= slope_new;
                default:     restart_slope_reg <= restart_slope_reg;
            endcase
        end
    end

    // result register
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] scan_row_reg;
    logic                         row_valid_reg;
    logic signed [COORD_BITS-1:0] span_left_reg;
    logic signed [COORD_BITS-1:0] span_right_reg;
    logic                         left_in_range_reg;
    logic                         right_in_range_reg;
    logic                         last_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.setup_emit || cmd.step_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup_emit || (cmd.step_emit && !walking_reg))
        begin
            scan_row_reg       <= sat(EDGE_W'(cur_row_reg));
            row_valid_reg      <= 1'b0;
            span_left_reg      <= '0;
            span_right_reg     <= '0;
            left_in_range_reg  <= 1'b0;
            right_in_range_reg <= 1'b0;
            last_row_reg       <= cmd.setup_emit ? !setup_walk : 1'b1;
        end
        else if (cmd.step_emit)
        begin
            scan_row_reg       <= sat(EDGE_W'(cur_row_reg));
            row_valid_reg      <= row_ok;
            span_left_reg      <= sat(col_l);
            span_right_reg     <= sat(col_r);
            left_in_range_reg  <= row_ok && (col_l >= 0) && (col_l < col_lim_s);
            right_in_range_reg <= row_ok && (col_r >= 0) && (col_r < col_lim_s);
            last_row_reg       <= !can_walk(row_next, fin_row_reg, row_lim_s);
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign scan_row       = scan_row_reg;
    assign row_valid      = row_valid_reg;
    assign span_left      = span_left_reg;
    assign span_right     = span_right_reg;
    assign left_in_range  = left_in_range_reg;
    assign right_in_range = right_in_range_reg;
    assign last_row       = last_row_reg;

endmodule

FILE: rtl/core/tesw_ctrl.sv
// controller: sequences set-up, slope divisions and scanline steps
module tesw_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   opcode,
    output logic                   in_stall,
    input  tesw_pkg::tesw_status_t status,
    output tesw_pkg::tesw_cmd_t    cmd
);

    import tesw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SETUP_OUT,
        S_STEP_OUT
    } state_t;

    state_t     state_reg;
    slope_sel_t sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_LEFT;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= (opcode == OP_LOAD) ? S_SORT : S_STEP_OUT;
                    end
                end
                S_SORT:
                begin
                    sel_reg   <= SEL_LEFT;
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (status.div_done)
                    begin
                        unique case (sel_reg)
                            SEL_LEFT:
                            begin
                                sel_reg   <= SEL_RIGHT;
                                state_reg <= S_DIV_GO;
                            end
                            SEL_RIGHT:
                            begin
                                sel_reg   <= SEL_RESTART;
                                state_reg <= S_DIV_GO;
                            end
                            default:
                            begin
                                state_reg <= S_SETUP_OUT;
                            end
                        endcase
                    end
                end
                S_SETUP_OUT, S_STEP_OUT:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.capture     = in_valid && (state_reg == S_IDLE);
        cmd.sort_load   = (state_reg == S_SORT);
        cmd.div_start   = (state_reg == S_DIV_GO);
        cmd.div_sel     = sel_reg;
        cmd.slope_write = (state_reg == S_DIV_WAIT) && status.div_done;
        cmd.setup_emit  = (state_reg == S_SETUP_OUT) && status.out_free;
        cmd.step_emit   = (state_reg == S_STEP_OUT) && status.out_free;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: rtl/core/triangle_edge_scan_walker_unit.sv
// top level of the triangle edge scan walker
//
// input channel (in_valid / in_stall): opcode load takes three vertices in signed
// fixed point, sorts them by y and sets up both edges; opcode step walks one scanline.
// output channel (out_valid / out_stall): exactly one result per input transfer.
// config port: cfg_write_en with cfg_index 0 writes column_limit, 1 writes row_limit.
// one item is in work at a time; the input is free again once the result is written
// to the output register, even while that result still waits.
// step: accept, then one edge add and compare into the result.
// load: accept, sort, then the shared one-bit-per-cycle slope divider runs three
// divisions in turn before the set-up result is written.
// reset clears the walker: a step before any load reports row 0 with last_row set;
// limits return to 512 columns and 256 rows.
// when out_stall holds, the finished result stays in the output register and the
// next item is accepted but waits until that transfer completes.
module triangle_edge_scan_walker_unit #(
    parameter int FRAC_BITS  = tesw_pkg::DEF_FRAC_BITS,
    parameter int COORD_BITS = tesw_pkg::DEF_COORD_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [tesw_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tesw_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   opcode,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] vert_a_x,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] vert_a_y,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] vert_b_x,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] vert_b_y,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] vert_c_x,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] vert_c_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [COORD_BITS-1:0]           scan_row,
    output logic                                   row_valid,
    output logic signed [COORD_BITS-1:0]           span_left,
    output logic signed [COORD_BITS-1:0]           span_right,
    output logic                                   left_in_range,
    output logic                                   right_in_range,
    output logic                                   last_row
);

    import tesw_pkg::*;

    tesw_cmd_t    cmd;
    tesw_status_t status;

    tesw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tesw_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .vert_a_x       (vert_a_x),
        .vert_a_y       (vert_a_y),
        .vert_b_x       (vert_b_x),
        .vert_b_y       (vert_b_y),
        .vert_c_x       (vert_c_x),
        .vert_c_y       (vert_c_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .scan_row       (scan_row),
        .row_valid      (row_valid),
        .span_left      (span_left),
        .span_right     (span_right),
        .left_in_range  (left_in_range),
        .right_in_range (right_in_range),
        .last_row       (last_row)
    );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// testbench for the triangle edge scan walker: directed plan, then random triangles walked row by row
module tb;
    import tesw_pkg::*;

    localparam int FRAC        = DEF_FRAC_BITS;
    localparam int COORD       = DEF_COORD_BITS;
    localparam int IN_W        = COORD + FRAC;
    localparam int Q           = 1 << FRAC;
    localparam int DIR_N       = 25;
    localparam int PHASES      = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic                   op;
        logic signed [IN_W-1:0] ax;
        logic signed [IN_W-1:0] ay;
        logic signed [IN_W-1:0] bx;
        logic signed [IN_W-1:0] by;
        logic signed [IN_W-1:0] cx;
        logic signed [IN_W-1:0] cy;
    } tri_item_t;

    typedef struct packed {
        logic signed [COORD-1:0] row;
        logic                    rv;
        logic signed [COORD-1:0] sl;
        logic signed [COORD-1:0] sr;
        logic                    lin;
        logic                    rin;
        logic                    last;
    } span_t;

    typedef struct packed {
        tri_item_t cmd;
        logic      known;
        span_t     want;
    } plan_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_write_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    opcode;
    logic signed [IN_W-1:0]  vert_a_x;
    logic signed [IN_W-1:0]  vert_a_y;
    logic signed [IN_W-1:0]  vert_b_x;
    logic signed [IN_W-1:0]  vert_b_y;
    logic signed [IN_W-1:0]  vert_c_x;
    logic signed [IN_W-1:0]  vert_c_y;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [COORD-1:0] scan_row;
    logic                    row_valid;
    logic signed [COORD-1:0] span_left;
    logic signed [COORD-1:0] span_right;
    logic                    left_in_range;
    logic                    right_in_range;
    logic                    last_row;

    // walker image kept by the bench
    logic [CFG_W-1:0]          col_lim = COLUMN_LIMIT_RESET;
    logic [CFG_W-1:0]          row_lim = ROW_LIMIT_RESET;
    logic signed [EDGE_W-1:0]  left_x = '0;
    logic signed [EDGE_W-1:0]  right_x = '0;
    logic signed [SLOPE_W-1:0] left_dx = '0;
    logic signed [SLOPE_W-1:0] right_dx = '0;
    logic signed [COORD:0]     row_now = '0;
    logic signed [COORD:0]     row_mid = '0;
    logic signed [COORD:0]     row_end = '0;
    logic signed [IN_W-1:0]    mid_x = '0;
    logic signed [IN_W-1:0]    end_x = '0;
    logic                      busy_walk = 1'b0;

    span_t     spans_due[$];
    plan_row_t plan[DIR_N];
    int        mismatches = 0;
    int        cycles = 0;
    int        stall_left = 0;
    bit        idle_in = 1'b0;
    bit        idle_out = 1'b0;

    triangle_edge_scan_walker_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .vert_a_x       (vert_a_x),
        .vert_a_y       (vert_a_y),
        .vert_b_x       (vert_b_x),
        .vert_b_y       (vert_b_y),
        .vert_c_x       (vert_c_x),
        .vert_c_y       (vert_c_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .scan_row       (scan_row),
        .row_valid      (row_valid),
        .span_left      (span_left),
        .span_right     (span_right),
        .left_in_range  (left_in_range),
        .right_in_range (right_in_range),
        .last_row       (last_row)
    );

    always #5 clk = ~clk;

    function automatic longint row_of(longint v);
        return v / longint'(Q);
    endfunction

    function automatic logic signed [SLOPE_W-1:0] edge_slope(longint dx, longint dr);
        longint den;
        den = 1 + dr;
        if (den < 1)
        begin
            den = 1;
        end
        return SLOPE_W'(dx / den);
    endfunction

    function automatic logic signed [COORD-1:0] clamp_out(longint v);
        longint hi;
        hi = (longint'(1) << (COORD - 1)) - 1;
        if (v > hi)
        begin
            v = hi;
        end
        if (v < -hi - 1)
        begin
            v = -hi - 1;
        end
        return COORD'(v);
    endfunction

    function automatic logic walkable();
        return longint'(row_now) <= longint'(row_end) && longint'(row_now) < longint'(row_lim);
    endfunction

    function automatic span_t walk_scanline(tri_item_t it);
        span_t  res;
        longint x[3];
        longint y[3];
        longint t;
        longint lo;
        longint hi;
        longint l;
        longint r;
        logic   on_row;
        int     i;
        res = '0;
        if (it.op == OP_LOAD)
        begin
            x[0] = longint'($signed(it.ax));
            y[0] = longint'($signed(it.ay));
            x[1] = longint'($signed(it.bx));
            y[1] = longint'($signed(it.by));
            x[2] = longint'($signed(it.cx));
            y[2] = longint'($signed(it.cy));
            // three compare-swaps, strict so equal y keeps order
            for (int k = 0; k < 3; k++)
            begin
                i = (k == 1) ? 1 : 0;
                if (y[i] > y[i+1])
                begin
                    t = x[i];
                    x[i] = x[i+1];
                    x[i+1] = t;
                    t = y[i];
                    y[i] = y[i+1];
                    y[i+1] = t;
                end
            end
            row_now = (COORD+1)'(row_of(y[0]));
            row_mid = (COORD+1)'(row_of(y[1]));
            row_end = (COORD+1)'(row_of(y[2]));
            mid_x = IN_W'(x[1]);
            end_x = IN_W'(x[2]);
            left_x = EDGE_W'(x[0]);
            right_x = EDGE_W'(x[0]);
            left_dx = edge_slope(x[1] - x[0], longint'(row_mid) - longint'(row_now));
            right_dx = edge_slope(x[2] - x[0], longint'(row_end) - longint'(row_now));
            busy_walk = walkable();
            res.row = clamp_out(longint'(row_now));
            res.last = !busy_walk;
            return res;
        end
        if (!busy_walk)
        begin
            res.row = clamp_out(longint'(row_now));
            res.last = 1'b1;
            return res;
        end
        if (row_now == row_mid)
        begin
            left_x = EDGE_W'(longint'(mid_x));
            left_dx = edge_slope(longint'(end_x) - longint'(mid_x),
                                 longint'(row_end) - longint'(row_mid));
        end
        lo = (longint'(left_x) < longint'(right_x)) ? longint'(left_x) : longint'(right_x);
        hi = (longint'(left_x) < longint'(right_x)) ? longint'(right_x) : longint'(left_x);
        l = row_of(lo);
        r = row_of(hi);
        on_row = longint'(row_now) >= 0 && longint'(row_now) < longint'(row_lim);
        res.row = clamp_out(longint'(row_now));
        res.rv = on_row;
        res.sl = clamp_out(l);
        res.sr = clamp_out(r);
        res.lin = on_row && l >= 0 && l < longint'(col_lim);
        res.rin = on_row && r >= 0 && r < longint'(col_lim);
        left_x = EDGE_W'(longint'(left_x) + longint'(left_dx));
        right_x = EDGE_W'(longint'(right_x) + longint'(right_dx));
        row_now = row_now + 1;
        busy_walk = walkable();
        res.last = !busy_walk;
        return res;
    endfunction

    function automatic logic signed [IN_W-1:0] coord(int whole);
        if (whole > 2047)
        begin
            whole = 2047;
        end
        if (whole < -2048)
        begin
            whole = -2048;
        end
        return IN_W'(whole * Q + int'($urandom_range(0, Q - 1)));
    endfunction

    function automatic tri_item_t random_triangle();
        tri_item_t it;
        int        base_row;
        int        base_col;
        base_row = int'($urandom_range(0, int'(row_lim) + 10)) - 6;
        if (base_row > 2020)
        begin
            base_row = 2020;
        end
        base_col = int'($urandom_range(0, int'(col_lim) + 80)) - 40;
        it.op = OP_LOAD;
        it.ax = coord(base_col + int'($urandom_range(0, 400)) - 200);
        it.ay = coord(base_row + int'($urandom_range(0, 25)));
        it.bx = coord(base_col + int'($urandom_range(0, 400)) - 200);
        it.by = coord(base_row + int'($urandom_range(0, 25)));
        it.cx = coord(base_col + int'($urandom_range(0, 400)) - 200);
        it.cy = coord(base_row + int'($urandom_range(0, 25)));
        if ($urandom_range(0, 7) == 0)
        begin
            it.by = it.ay;
        end
        return it;
    endfunction

    function automatic tri_item_t noise_item(logic op);
        tri_item_t it;
        it.op = op;
        it.ax = IN_W'($urandom());
        it.ay = IN_W'($urandom());
        it.bx = IN_W'($urandom());
        it.by = IN_W'($urandom());
        it.cx = IN_W'($urandom());
        it.cy = IN_W'($urandom());
        return it;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic send(tri_item_t it, logic known, span_t want);
        span_t got;
        if (idle_in && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= it.op;
        vert_a_x <= it.ax;
        vert_a_y <= it.ay;
        vert_b_x <= it.bx;
        vert_b_y <= it.by;
        vert_c_x <= it.cx;
        vert_c_y <= it.cy;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        got = walk_scanline(it);
        spans_due.insert(spans_due.size(), known ? want : got);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (spans_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_limits(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
        cfg_write_en <= 1'b1;
        cfg_index <= CFG_COLUMN_LIMIT;
        cfg_data <= cols;
        @(negedge clk);
        cfg_index <= CFG_ROW_LIMIT;
        cfg_data <= rows;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        col_lim = cols;
        row_lim = rows;
    endtask

    task automatic run_traffic(int count, bit vary);
        int n;
        int pick;
        n = 0;
        while (n < count)
        begin
            if (vary && $urandom_range(0, 30) == 0)
            begin
                idle_in = $urandom_range(0, 1);
                idle_out = $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 19);
            if (pick < 15)
            begin
                // whole triangle walked row by row, sometimes cut short by a new load
                send(random_triangle(), 1'b0, '0);
                n++;
                while (busy_walk && $urandom_range(0, 59) != 0)
                begin
                    send(noise_item(OP_STEP), 1'b0, '0);
                    n++;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    send(noise_item(OP_STEP), 1'b0, '0);
                    n++;
                end
            end
            else if (pick < 18)
            begin
                send(noise_item(OP_LOAD), 1'b0, '0);
                n++;
                repeat ($urandom_range(0, 4))
                begin
                    send(noise_item(OP_STEP), 1'b0, '0);
                    n++;
                end
            end
            else
            begin
                send(noise_item(OP_STEP), 1'b0, '0);
                n++;
            end
            if ($urandom_range(0, 40) == 0)
            begin
                drain();
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
        end
        else if (idle_out && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 13);
        end
        out_stall <= (stall_left != 0);
    end

    always @(posedge clk)
    begin : span_check
        span_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (spans_due.size() == 0)
            begin
                $display("%0t transfer expected none actual row %0d", $time, scan_row);
                mismatches++;
            end
            else
            begin
                due = spans_due.pop_front();
                check_field("scan_row", longint'($signed(due.row)), longint'(scan_row));
                check_field("row_valid", due.rv, row_valid);
                check_field("span_left", longint'($signed(due.sl)), longint'(span_left));
                check_field("span_right", longint'($signed(due.sr)), longint'(span_right));
                check_field("left_in_range", due.lin, left_in_range);
                check_field("right_in_range", due.rin, right_in_range);
                check_field("last_row", due.last, last_row);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int col_set[PHASES];
        int row_set[PHASES];
        int item_count[PHASES];
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_COLUMN_LIMIT;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_LOAD;
        vert_a_x = '0;
        vert_a_y = '0;
        vert_b_x = '0;
        vert_b_y = '0;
        vert_c_x = '0;
        vert_c_y = '0;
        col_set = '{2048, 1, 2048, 100, 640, 1, 0, 512};
        row_set = '{2048, 1, 0, 40, 480, 2048, 0, 256};
        item_count = '{150, 130, 40, 150, 150, 150, 150, 230};
        col_set[6] = $urandom_range(1, 2048);
        row_set[6] = $urandom_range(1, 2048);
        plan = '{
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 1}},
            '{'{OP_LOAD, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 1, 0, 0, 1, 1, 1}},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b1, '{1, 0, 0, 0, 0, 0, 1}},
            '{'{OP_LOAD, -524288, -524288, 524287, 524287, 0, 0}, 1'b1,
              '{-2048, 0, 0, 0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b1, '{-2048, 0, -2048, -2048, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_LOAD, 524287, 524287, 524287, 524287, 524287, 524287}, 1'b1,
              '{2047, 0, 0, 0, 0, 0, 1}},
            '{'{OP_STEP, -1, -1, -1, -1, -1, -1}, 1'b1, '{2047, 0, 0, 0, 0, 0, 1}},
            '{'{OP_LOAD, 10*Q, 5*Q, 20*Q, 5*Q, 30*Q, 5*Q}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_LOAD, 40*Q + 'hAB, 30*Q + 'h7F, 5*Q + 1, 20*Q + 'hFF,
                -3*Q - 'h40, 10*Q + 'h80}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_LOAD, 10*Q, 254*Q, -20*Q, 255*Q, 700*Q, 400*Q}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_LOAD, 100*Q, -128, -50*Q, -3*Q, 520*Q, 2*Q}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
            '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, 1'b0, '0}
        };
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_in = 1'b1;
        idle_out = 1'b1;
        for (int i = 0; i < DIR_N; i++)
        begin
            send(plan[i].cmd, plan[i].known, plan[i].want);
        end
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (p == PHASES - 1)
            begin
                idle_in = 1'b0;
                idle_out = 1'b0;
            end
            set_limits(CFG_W'(col_set[p]), CFG_W'(row_set[p]));
            run_traffic(item_count[p], p != PHASES - 1);
        end
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
